@@ rtl/flpa_pkg.sv @@
package flpa_pkg;

  localparam int POOL_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int IDX_W      = 11;
  localparam int GRANT_W    = 10;
  localparam int STATUS_W   = 2;

  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(POOL_SLOTS);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

@@ rtl/flpa_ram.sv @@
module flpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/free_list_pool_allocator.sv @@
// Channel | Direction | Payload
// in_     | sink      | tuser: cmd; tdata: slot_index
// out_    | source    | tuser: status; tdata: granted_slot, in_use, free_left
//
// An allocate with a nonempty list goes from ST_IDLE to ST_READ: the link at the list
// head is read from the synchronous link memory before the new head is known. A free,
// a bad index or an exhausted pool is answered from ST_IDLE. After reset a clearing
// pass chains every slot to the next; no beat is accepted during it.
// A new beat is accepted only when the output register is empty or drains
// in the same cycle.
module free_list_pool_allocator
  import flpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [10:0] slot_index
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] granted_slot, [20:10] in_use, [31:21] free_left
  output logic [1:0]  out_tuser   // [1:0] status
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [SLOT_W-1:0]    init_cnt_r, init_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [GRANT_W-1:0]   out_slot_r, out_slot_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_used_r, out_used_nxt;
  logic [CNT_W-1:0]     out_free_r, out_free_nxt;

  logic                 ram_we, ram_re;
  logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0]     ram_wdata, ram_rdata;

  logic                 in_fire;
  logic                 emit;
  logic [GRANT_W-1:0]   emit_slot;
  status_t              emit_status;
  cmd_t                 in_cmd;
  logic [IDX_W-1:0]     in_idx;
  logic                 head_empty;

  assign in_cmd     = cmd_t'(in_tuser[0]);
  assign in_idx     = in_tdata[IDX_W-1:0];
  assign head_empty = (head_r >= END_MARK);
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;

  flpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    init_cnt_nxt   = init_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_waddr      = head_r[SLOT_W-1:0];
    ram_wdata      = head_r;
    ram_re         = 1'b0;
    ram_raddr      = head_r[SLOT_W-1:0];
    emit           = 1'b0;
    emit_slot      = '0;
    emit_status    = STAT_OK;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = init_cnt_r;
        ram_wdata    = CNT_W'(init_cnt_r) + CNT_W'(1);
        init_cnt_nxt = init_cnt_r + SLOT_W'(1);
        if (init_cnt_r == SLOT_W'(POOL_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_ALLOC) begin
            if (head_empty) begin
              emit        = 1'b1;
              emit_status = STAT_EXHAUSTED;
            end else begin
              ram_re    = 1'b1;
              state_nxt = ST_READ;
            end
          end else if (in_idx >= IDX_W'(POOL_SLOTS)) begin
            emit        = 1'b1;
            emit_status = STAT_BAD_INDEX;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = in_idx[SLOT_W-1:0];
            ram_wdata = head_r;
            head_nxt  = CNT_W'(in_idx);
            if (used_r != '0) begin
              used_nxt = used_r - CNT_W'(1);
            end
            emit = 1'b1;
          end
        end
      end
      ST_READ: begin
        head_nxt = (ram_rdata > END_MARK) ? END_MARK : ram_rdata;
        if (used_r < END_MARK) begin
          used_nxt = used_r + CNT_W'(1);
        end
        emit      = 1'b1;
        emit_slot = GRANT_W'(head_r[SLOT_W-1:0]);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = emit_slot;
      out_status_nxt = emit_status;
      out_used_nxt   = used_nxt;
      out_free_nxt   = END_MARK - used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      head_r      <= '0;
      used_r      <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_free_r, out_used_r, out_slot_r};
  assign out_tuser  = out_status_r;

  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_used_r + out_free_r) == END_MARK)
    else $error("in_use and free_left do not add up to the pool size");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !in_tready)
    else $error("beat accepted during the clearing pass");

  a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_ALLOC && !head_empty) |=> (state_r == ST_READ))
    else $error("allocate with a nonempty list did not read the link");

  a_err_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> (out_slot_r == '0))
    else $error("failed request carries a nonzero slot");

  a_read_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("allocate result would overwrite a pending beat");

endmodule
